// File: sv/dkr_pkg.sv
// shared types, codes and helpers of the disk controller register front end
`timescale 1ns / 1ps

package dkr_pkg;

    // bus function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_ACK   = 2'd2;

    // register select, address bits 3:1
    localparam logic [2:0] REG_DS = 3'd0;
    localparam logic [2:0] REG_ER = 3'd1;
    localparam logic [2:0] REG_CS = 3'd2;
    localparam logic [2:0] REG_WC = 3'd3;
    localparam logic [2:0] REG_BA = 3'd4;
    localparam logic [2:0] REG_DA = 3'd5;

    // command codes, control bits 3:1
    localparam logic [2:0] OP_CTLRESET = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_READ     = 3'd2;
    localparam logic [2:0] OP_WCHK     = 3'd3;
    localparam logic [2:0] OP_SEEK     = 3'd4;
    localparam logic [2:0] OP_DRVRESET = 3'd6;
    localparam logic [2:0] OP_WLOCK    = 3'd7;

    // transfer kinds handed to the data engine
    localparam logic [1:0] XK_READ  = 2'd0;
    localparam logic [1:0] XK_WRITE = 2'd1;
    localparam logic [1:0] XK_WCHK  = 2'd2;

    // control/status bits
    localparam logic [15:0] CS_GO   = 16'o000001;
    localparam logic [15:0] CS_IE   = 16'o000100;
    localparam logic [15:0] CS_DONE = 16'o000200;
    localparam logic [15:0] CS_MEX  = 16'o000060;
    localparam logic [15:0] CS_FMT  = 16'o002000;
    localparam logic [15:0] CS_INH  = 16'o004000;
    localparam logic [15:0] CS_SCP  = 16'o020000;
    localparam logic [15:0] CS_HERR = 16'o040000;
    localparam logic [15:0] CS_ERR  = 16'o100000;
    localparam logic [15:0] CS_RW   = 16'o006576;

    // error bits
    localparam logic [15:0] ER_SOFT = 16'o000003;
    localparam logic [15:0] ER_NXS  = 16'o000040;
    localparam logic [15:0] ER_NXC  = 16'o000100;
    localparam logic [15:0] ER_PGE  = 16'o004000;
    localparam logic [15:0] ER_WLK  = 16'o020000;
    localparam logic [15:0] ER_HARD = 16'o177740;

    localparam logic [15:0] DS_VALUE = 16'o004400;
    localparam logic [7:0]  VEC_DK   = 8'o220;
    localparam logic [7:0]  NUM_CYL  = 8'd203;
    localparam logic [3:0]  NUM_SECT = 4'd12;

    // x / 3 as (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2**17
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    // configuration register index
    localparam logic CFG_REG_WP = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  reg_offset;
        logic [15:0] write_data;
        logic        byte_write;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq;
        logic [7:0]  vector;
        logic        xfer_start;
        logic [1:0]  xfer_kind;
        logic        xfer_format;
        logic        xfer_inhibit;
        logic [20:0] xfer_disk_word;
        logic [17:0] xfer_mem_addr;
        logic [16:0] xfer_words;
    } t_out_item;

    typedef struct packed {
        logic        sect_bad;
        logic        cyl_bad;
        logic [20:0] disk_word;
        logic [17:0] mem_addr;
        logic [16:0] words;
        logic [17:0] next_ma;
        logic [15:0] next_da;
    } t_xfer_calc;

    function automatic logic [15:0] dkr_merge(
        input logic [15:0] old_val,
        input logic [15:0] data,
        input logic        bytew,
        input logic        high
    );
        logic [15:0] res;
        if (!bytew) begin
            res = data;
        end else if (high) begin
            res = {data[7:0], old_val[7:0]};
        end else begin
            res = {old_val[15:8], data[7:0]};
        end
        return res;
    endfunction

endpackage

// File: sv/dkr_xfer.sv
// transfer parameters and post-transfer address arithmetic
`timescale 1ns / 1ps

module dkr_xfer (
    input  logic [15:0]          i_da,
    input  logic [15:0]          i_ba,
    input  logic [15:0]          i_wc,
    input  logic [1:0]           i_mex,
    input  logic                 i_inh,
    input  logic                 i_fmt_read,
    output dkr_pkg::t_xfer_calc  o_calc
);

    logic [3:0]  sector;
    logic [7:0]  cyl;
    logic [8:0]  track;
    logic [12:0] blk0;
    logic [17:0] ma;
    logic [16:0] words;
    logic [16:0] words_rnd;
    logic [16:0] inc;
    logic [16:0] x;
    logic [30:0] prod;
    logic [13:0] q;
    logic [16:0] rem;
    logic [11:0] new_track;

    assign sector = i_da[3:0];
    assign cyl    = i_da[12:5];
    assign track  = i_da[12:4];

    assign blk0  = ({4'd0, track} * {9'd0, dkr_pkg::NUM_SECT}) + {9'd0, sector};
    assign ma    = {i_mex, i_ba};
    assign words = 17'h10000 - {1'b0, i_wc};

    // whole blocks touched by the transfer
    assign words_rnd = words + 17'd255;
    assign inc       = i_fmt_read ? words : {8'd0, words_rnd[16:8]};
    assign x         = inc + {13'd0, sector};

    // x / 12 as (x / 4) / 3
    assign prod      = {16'd0, x[16:2]} * {15'd0, dkr_pkg::DIV3_MUL};
    assign q         = prod[30:dkr_pkg::DIV3_SHIFT];
    assign rem       = x - ({3'd0, q} * {13'd0, dkr_pkg::NUM_SECT});
    assign new_track = {3'd0, track} + q[11:0];

    always_comb begin
        o_calc.sect_bad  = (sector >= dkr_pkg::NUM_SECT);
        o_calc.cyl_bad   = (cyl >= dkr_pkg::NUM_CYL);
        o_calc.disk_word = {blk0, 8'd0};
        o_calc.mem_addr  = ma;
        o_calc.words     = words;
        o_calc.next_ma   = i_inh ? ma : (ma + {words, 1'b0});
        o_calc.next_da   = {new_track, rem[3:0]};
    end

endmodule

// File: sv/dkr_regs.sv
// register file, command decode and interrupt queue
`timescale 1ns / 1ps

module dkr_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  dkr_pkg::t_in_item    i_item,
    input  logic                 i_wp,
    output dkr_pkg::t_out_item   o_result
);

    logic [15:0] r_cs, n_cs;
    logic [15:0] r_err, n_err;
    logic [15:0] r_wc, n_wc;
    logic [15:0] r_ba, n_ba;
    logic [15:0] r_da, n_da;
    logic [1:0]  r_iq, n_iq;
    logic        r_rl, n_rl;

    logic [2:0]  reg_sel;
    logic        high_byte;
    logic [15:0] cs_d;
    logic [15:0] cs_w;
    logic [2:0]  go_op;
    logic        fmt;
    logic        do_xfer;
    logic        do_seek;
    logic [15:0] fin_err;
    dkr_pkg::t_xfer_calc calc;
    dkr_pkg::t_out_item  res;

    assign reg_sel   = i_item.reg_offset[3:1];
    assign high_byte = i_item.reg_offset[0];
    assign cs_d      = dkr_pkg::dkr_merge(r_cs, i_item.write_data, i_item.byte_write, high_byte);
    assign cs_w      = (r_cs & ~dkr_pkg::CS_RW) | (cs_d & dkr_pkg::CS_RW);
    assign go_op     = cs_w[3:1];
    assign fmt       = (cs_w & dkr_pkg::CS_FMT) != 16'd0;

    dkr_xfer u_xfer (
        .i_da       (r_da),
        .i_ba       (r_ba),
        .i_wc       (r_wc),
        .i_mex      (cs_w[5:4]),
        .i_inh      ((cs_w & dkr_pkg::CS_INH) != 16'd0),
        .i_fmt_read (fmt && (go_op == dkr_pkg::OP_READ)),
        .o_calc     (calc)
    );

    always_comb begin
        n_cs    = r_cs;
        n_err   = r_err;
        n_wc    = r_wc;
        n_ba    = r_ba;
        n_da    = r_da;
        n_iq    = r_iq;
        n_rl    = r_rl;
        res     = '0;
        do_xfer = 1'b0;
        do_seek = 1'b0;
        fin_err = 16'd0;
        if (i_valid) begin
            unique case (i_item.func)
                dkr_pkg::FUNC_READ: begin
                    unique case (reg_sel)
                        dkr_pkg::REG_DS: res.read_data = dkr_pkg::DS_VALUE;
                        dkr_pkg::REG_ER: res.read_data = r_err;
                        dkr_pkg::REG_CS: begin
                            if (r_err != 16'd0) n_cs = n_cs | dkr_pkg::CS_ERR;
                            if ((r_err & dkr_pkg::ER_HARD) != 16'd0) n_cs = n_cs | dkr_pkg::CS_HERR;
                            res.read_data = n_cs;
                        end
                        dkr_pkg::REG_WC: res.read_data = r_wc;
                        dkr_pkg::REG_BA: res.read_data = r_ba;
                        dkr_pkg::REG_DA: res.read_data = r_da;
                        default:         res.read_data = 16'd0;
                    endcase
                end
                dkr_pkg::FUNC_WRITE: begin
                    unique case (reg_sel)
                        dkr_pkg::REG_CS: begin
                            if ((cs_d & dkr_pkg::CS_IE) == 16'd0) begin
                                n_iq = 2'b00;
                                n_rl = 1'b0;
                            end else if ((r_cs & (dkr_pkg::CS_DONE | dkr_pkg::CS_IE))
                                         == dkr_pkg::CS_DONE) begin
                                n_iq = n_iq | 2'b01;
                                n_rl = 1'b1;
                            end
                            n_cs = cs_w;
                            if (((cs_w & dkr_pkg::CS_DONE) != 16'd0)
                                && ((cs_d & dkr_pkg::CS_GO) != 16'd0)) begin
                                if (go_op == dkr_pkg::OP_CTLRESET) begin
                                    n_err = 16'd0;
                                    n_da  = 16'd0;
                                    n_ba  = 16'd0;
                                    n_cs  = dkr_pkg::CS_DONE;
                                    n_iq  = 2'b00;
                                    n_rl  = 1'b0;
                                end else begin
                                    n_err = r_err & ~dkr_pkg::ER_SOFT;
                                    if (n_err == 16'd0) n_cs = n_cs & ~dkr_pkg::CS_ERR;
                                    n_cs = n_cs & ~(dkr_pkg::CS_SCP | dkr_pkg::CS_DONE);
                                    n_iq = n_iq & 2'b10;
                                    n_rl = 1'b0;
                                    if (fmt && (go_op != dkr_pkg::OP_READ)
                                        && (go_op != dkr_pkg::OP_WRITE)) begin
                                        fin_err = dkr_pkg::ER_PGE;
                                    end else if ((go_op == dkr_pkg::OP_WRITE) && i_wp) begin
                                        fin_err = dkr_pkg::ER_WLK;
                                    end else if (go_op == dkr_pkg::OP_WLOCK) begin
                                        fin_err = 16'd0;
                                    end else if (go_op == dkr_pkg::OP_DRVRESET) begin
                                        do_seek = 1'b1;
                                    end else if (calc.sect_bad) begin
                                        fin_err = dkr_pkg::ER_NXS;
                                    end else if (calc.cyl_bad) begin
                                        fin_err = dkr_pkg::ER_NXC;
                                    end else if (go_op == dkr_pkg::OP_SEEK) begin
                                        do_seek = 1'b1;
                                    end else begin
                                        do_xfer = 1'b1;
                                    end

                                    if (do_xfer) begin
                                        unique case (go_op)
                                            dkr_pkg::OP_READ: begin
                                                res.xfer_start = 1'b1;
                                                res.xfer_kind  = dkr_pkg::XK_READ;
                                            end
                                            dkr_pkg::OP_WRITE: begin
                                                res.xfer_start = 1'b1;
                                                res.xfer_kind  = dkr_pkg::XK_WRITE;
                                            end
                                            dkr_pkg::OP_WCHK: begin
                                                res.xfer_start = 1'b1;
                                                res.xfer_kind  = dkr_pkg::XK_WCHK;
                                            end
                                            default: res.xfer_start = 1'b0;
                                        endcase
                                        if (res.xfer_start) begin
                                            res.xfer_format    = fmt;
                                            res.xfer_inhibit   = (cs_w & dkr_pkg::CS_INH) != 16'd0;
                                            res.xfer_disk_word = calc.disk_word;
                                            res.xfer_mem_addr  = calc.mem_addr;
                                            res.xfer_words     = calc.words;
                                        end
                                        // the count always runs out to zero
                                        n_wc = 16'd0;
                                        n_ba = calc.next_ma[15:0];
                                        n_cs = (n_cs & ~dkr_pkg::CS_MEX)
                                             | {10'd0, calc.next_ma[17:16], 4'd0};
                                        n_da = calc.next_da;
                                    end

                                    // completion
                                    n_cs = n_cs | dkr_pkg::CS_DONE;
                                    if (fin_err != 16'd0) begin
                                        n_err = n_err | fin_err;
                                        if (n_err != 16'd0) n_cs = n_cs | dkr_pkg::CS_ERR;
                                        if ((n_err & dkr_pkg::ER_HARD) != 16'd0) begin
                                            n_cs = n_cs | dkr_pkg::CS_HERR;
                                        end
                                    end
                                    if ((n_cs & dkr_pkg::CS_IE) != 16'd0) begin
                                        n_iq = n_iq | 2'b01;
                                        n_rl = 1'b1;
                                    end else begin
                                        n_iq = 2'b00;
                                        n_rl = 1'b0;
                                    end

                                    if (do_seek) begin
                                        n_cs = n_cs | dkr_pkg::CS_SCP;
                                        if ((n_cs & dkr_pkg::CS_IE) != 16'd0) begin
                                            n_iq = n_iq | 2'b10;
                                            n_rl = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        dkr_pkg::REG_WC: begin
                            n_wc = dkr_pkg::dkr_merge(r_wc, i_item.write_data,
                                                      i_item.byte_write, high_byte);
                        end
                        dkr_pkg::REG_BA: begin
                            n_ba = dkr_pkg::dkr_merge(r_ba, i_item.write_data,
                                                      i_item.byte_write, high_byte);
                        end
                        dkr_pkg::REG_DA: begin
                            if ((r_cs & dkr_pkg::CS_DONE) != 16'd0) begin
                                n_da = dkr_pkg::dkr_merge(r_da, i_item.write_data,
                                                          i_item.byte_write, high_byte);
                            end
                        end
                        default: n_da = r_da;
                    endcase
                end
                dkr_pkg::FUNC_ACK: begin
                    if (r_iq[0]) begin
                        n_iq       = {r_iq[1], 1'b0};
                        res.vector = dkr_pkg::VEC_DK;
                        n_rl       = r_iq[1];
                    end else if (r_iq[1]) begin
                        n_iq       = 2'b00;
                        res.vector = dkr_pkg::VEC_DK;
                        n_rl       = 1'b0;
                    end else begin
                        n_iq = 2'b00;
                        n_rl = 1'b0;
                    end
                end
                default: n_rl = r_rl;
            endcase
            res.irq = n_rl;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs  <= dkr_pkg::CS_DONE;
            r_err <= 16'd0;
            r_wc  <= 16'd0;
            r_ba  <= 16'd0;
            r_da  <= 16'd0;
            r_iq  <= 2'b00;
            r_rl  <= 1'b0;
        end else begin
            r_cs  <= n_cs;
            r_err <= n_err;
            r_wc  <= n_wc;
            r_ba  <= n_ba;
            r_da  <= n_da;
            r_iq  <= n_iq;
            r_rl  <= n_rl;
        end
    end

    a_req_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rl |-> (r_iq != 2'b00))
        else $error("request line set with empty interrupt queue");

    a_queue_needs_ie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iq != 2'b00) |-> ((r_cs & dkr_pkg::CS_IE) != 16'd0))
        else $error("interrupt queued while interrupts disabled");

    a_done_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> ((r_cs & dkr_pkg::CS_DONE) != 16'd0))
        else $error("done flag clear after a beat");

    a_xfer_clears_wc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && res.xfer_start) |=> (r_wc == 16'd0))
        else $error("word count not exhausted after a transfer");

endmodule

// File: sv/disk_controller_registers_unit.sv
// top level: beat registers, register front end and configuration port
// an accepted beat is held in the input beat register, its result in the output one
// throughput: one beat per cycle unless the output stalls; each beat's register updates
//   through the sector/cylinder address arithmetic are registered before the next beat reads them
// reset: synchronous, active low; control reads done, all other registers and the
//   interrupt queue clear, write protect clears, both beat registers empty
`timescale 1ns / 1ps

module disk_controller_registers_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dkr_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dkr_pkg::t_out_item   o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic                r_in_valid;
    dkr_pkg::t_in_item   r_in_item;
    logic                r_out_valid;
    dkr_pkg::t_out_item  r_out_item;
    logic                r_wp;
    logic                advance;
    logic                exec;
    logic                accept;
    logic                cfg_wr;
    dkr_pkg::t_out_item  result;

    assign advance    = !r_out_valid || !i_out_stall;
    assign exec       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    dkr_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (exec),
        .i_item   (r_in_item),
        .i_wp     (r_wp),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == dkr_pkg::CFG_REG_WP);
    assign prdata = (paddr[2] == dkr_pkg::CFG_REG_WP) ? {31'd0, r_wp} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
        end else if (cfg_wr) begin
            r_wp <= pwdata[0];
        end
    end

endmodule

// File: test/disk_controller_registers_unit_tb.sv
// self-checking bench for the disk controller register front end: predicts every result beat
`timescale 1ns / 1ps

module disk_controller_registers_unit_tb;

    localparam int          CLK_HALF    = 4;
    localparam logic [1:0]  FUNC_NONE   = 2'd3;
    localparam logic [2:0]  OP_RD_CHECK = 3'd5;
    localparam logic [2:0]  REG_SPARE6  = 3'd6;
    localparam logic [2:0]  REG_SPARE7  = 3'd7;
    localparam logic [2:0]  WP_ADDR     = {dkr_pkg::CFG_REG_WP, 2'b00};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    dkr_pkg::t_in_item   i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    dkr_pkg::t_out_item  o_out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    disk_controller_registers_unit u_top (.*);

    // predicted controller state
    logic [15:0]         m_cs;
    logic [15:0]         m_er;
    logic [15:0]         m_wc;
    logic [15:0]         m_ba;
    logic [15:0]         m_da;
    logic [1:0]          m_ivq;
    logic                m_irq;
    logic                m_wlock;
    dkr_pkg::t_out_item  m_res;

    dkr_pkg::t_in_item   pending_q[$];
    dkr_pkg::t_out_item  expected_q[$];
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    bit                  rx_hold;
    bit                  in_beat;
    int                  beats_in;
    int                  err_count;

    function automatic logic [15:0] byte_merge(logic [15:0] old_v, logic [15:0] d,
                                               logic bw, logic hi);
        if (!bw) return d;
        return hi ? {d[7:0], old_v[7:0]} : {old_v[15:8], d[7:0]};
    endfunction

    function automatic void latch_errors();
        if (m_er != 16'd0) m_cs |= dkr_pkg::CS_ERR;
        if ((m_er & dkr_pkg::ER_HARD) != 16'd0) m_cs |= dkr_pkg::CS_HERR;
    endfunction

    function automatic void complete_cmd(logic [15:0] err);
        m_cs |= dkr_pkg::CS_DONE;
        if (err != 16'd0) begin
            m_er |= err;
            latch_errors();
        end
        if ((m_cs & dkr_pkg::CS_IE) != 16'd0) begin
            m_ivq[0] = 1'b1;
            m_irq = 1'b1;
        end else begin
            m_ivq = 2'b00;
            m_irq = 1'b0;
        end
    endfunction

    function automatic void run_transfer(logic [2:0] op);
        logic [31:0] trk;
        logic [31:0] sec;
        logic [31:0] ma;
        logic [31:0] dw;
        logic [31:0] words;
        logic [31:0] blk;
        logic [31:0] nda;
        logic        fmt;
        logic        inh;
        sec = {28'd0, m_da[3:0]};
        trk = {23'd0, m_da[12:4]};
        ma = {14'd0, m_cs[5:4], m_ba};
        fmt = (m_cs & dkr_pkg::CS_FMT) != 16'd0;
        inh = (m_cs & dkr_pkg::CS_INH) != 16'd0;
        dw = (trk * 32'd12 + sec) * 32'd256;
        words = 32'h10000 - {16'd0, m_wc};
        if (op == dkr_pkg::OP_READ || op == dkr_pkg::OP_WRITE || op == dkr_pkg::OP_WCHK) begin
            m_res.xfer_start = 1'b1;
            m_res.xfer_kind = (op == dkr_pkg::OP_READ) ? dkr_pkg::XK_READ :
                              (op == dkr_pkg::OP_WRITE) ? dkr_pkg::XK_WRITE :
                              dkr_pkg::XK_WCHK;
            m_res.xfer_format = fmt;
            m_res.xfer_inhibit = inh;
            m_res.xfer_disk_word = dw[20:0];
            m_res.xfer_mem_addr = ma[17:0];
            m_res.xfer_words = words[16:0];
        end
        m_wc = m_wc + words[15:0];
        if (!inh) ma = (ma + (words << 1)) & 32'h3FFFF;
        m_ba = ma[15:0];
        m_cs = (m_cs & ~dkr_pkg::CS_MEX) | {10'd0, ma[17:16], 4'd0};
        if (op == dkr_pkg::OP_READ && fmt) dw = dw + words * 32'd256;
        else dw = dw + words + 32'd255;
        blk = dw / 32'd256;
        nda = ((blk / 32'd12) << 4) | (blk % 32'd12);
        m_da = nda[15:0];
        complete_cmd(16'd0);
    endfunction

    function automatic void start_cmd();
        logic [2:0]  op;
        logic [15:0] sec;
        logic [15:0] cyl;
        op = m_cs[3:1];
        if (op == dkr_pkg::OP_CTLRESET) begin
            m_er = 16'd0;
            m_da = 16'd0;
            m_ba = 16'd0;
            m_cs = dkr_pkg::CS_DONE;
            m_ivq = 2'b00;
            m_irq = 1'b0;
            return;
        end
        m_er &= ~dkr_pkg::ER_SOFT;
        if (m_er == 16'd0) m_cs &= ~dkr_pkg::CS_ERR;
        m_cs &= ~(dkr_pkg::CS_SCP | dkr_pkg::CS_DONE);
        m_ivq[0] = 1'b0;
        m_irq = 1'b0;
        if ((m_cs & dkr_pkg::CS_FMT) != 16'd0 && op != dkr_pkg::OP_READ
            && op != dkr_pkg::OP_WRITE) begin
            complete_cmd(dkr_pkg::ER_PGE);
            return;
        end
        if (op == dkr_pkg::OP_WRITE && m_wlock) begin
            complete_cmd(dkr_pkg::ER_WLK);
            return;
        end
        if (op == dkr_pkg::OP_WLOCK) begin
            complete_cmd(16'd0);
            return;
        end
        if (op == dkr_pkg::OP_DRVRESET) begin
            sec = 16'd0;
            cyl = 16'd0;
            op = dkr_pkg::OP_SEEK;
        end else begin
            sec = {12'd0, m_da[3:0]};
            cyl = {8'd0, m_da[12:5]};
        end
        if (sec >= 16'd12) begin
            complete_cmd(dkr_pkg::ER_NXS);
            return;
        end
        if (cyl >= 16'd203) begin
            complete_cmd(dkr_pkg::ER_NXC);
            return;
        end
        if (op == dkr_pkg::OP_SEEK) begin
            complete_cmd(16'd0);
            m_cs |= dkr_pkg::CS_SCP;
            if ((m_cs & dkr_pkg::CS_IE) != 16'd0) begin
                m_ivq[1] = 1'b1;
                if ((m_cs & dkr_pkg::CS_DONE) != 16'd0) m_irq = 1'b1;
            end else begin
                m_ivq = 2'b00;
                m_irq = 1'b0;
            end
            return;
        end
        run_transfer(op);
    endfunction

    function automatic dkr_pkg::t_out_item predict_beat(dkr_pkg::t_in_item b);
        logic [15:0] d;
        logic [2:0]  sel;
        logic        hi;
        m_res = '0;
        sel = b.reg_offset[3:1];
        hi = b.reg_offset[0];
        case (b.func)
            dkr_pkg::FUNC_READ: begin
                case (sel)
                    dkr_pkg::REG_DS: m_res.read_data = dkr_pkg::DS_VALUE;
                    dkr_pkg::REG_ER: m_res.read_data = m_er;
                    dkr_pkg::REG_CS: begin
                        latch_errors();
                        m_res.read_data = m_cs;
                    end
                    dkr_pkg::REG_WC: m_res.read_data = m_wc;
                    dkr_pkg::REG_BA: m_res.read_data = m_ba;
                    dkr_pkg::REG_DA: m_res.read_data = m_da;
                    default: m_res.read_data = 16'd0;
                endcase
            end
            dkr_pkg::FUNC_WRITE: begin
                case (sel)
                    dkr_pkg::REG_CS: begin
                        d = byte_merge(m_cs, b.write_data, b.byte_write, hi);
                        if ((d & dkr_pkg::CS_IE) == 16'd0) begin
                            m_ivq = 2'b00;
                            m_irq = 1'b0;
                        end else if ((m_cs & (dkr_pkg::CS_DONE | dkr_pkg::CS_IE))
                                     == dkr_pkg::CS_DONE) begin
                            m_ivq[0] = 1'b1;
                            m_irq = 1'b1;
                        end
                        m_cs = (m_cs & ~dkr_pkg::CS_RW) | (d & dkr_pkg::CS_RW);
                        if ((m_cs & dkr_pkg::CS_DONE) != 16'd0
                            && (d & dkr_pkg::CS_GO) != 16'd0) start_cmd();
                    end
                    dkr_pkg::REG_WC: m_wc = byte_merge(m_wc, b.write_data, b.byte_write, hi);
                    dkr_pkg::REG_BA: m_ba = byte_merge(m_ba, b.write_data, b.byte_write, hi);
                    dkr_pkg::REG_DA: begin
                        if ((m_cs & dkr_pkg::CS_DONE) != 16'd0)
                            m_da = byte_merge(m_da, b.write_data, b.byte_write, hi);
                    end
                    default: ;
                endcase
            end
            dkr_pkg::FUNC_ACK: begin
                if (m_ivq != 2'b00) begin
                    if (m_ivq[0]) m_ivq[0] = 1'b0;
                    else m_ivq[1] = 1'b0;
                    m_res.vector = dkr_pkg::VEC_DK;
                    m_irq = (m_ivq != 2'b00);
                end else begin
                    m_irq = 1'b0;
                end
            end
            default: ;
        endcase
        m_res.irq = m_irq;
        return m_res;
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic cmp_field(string fname, logic [31:0] got, logic [31:0] want);
        if (got !== want) flag_error($sformatf("%s got %0h expected %0h", fname, got, want));
    endtask

    function automatic logic [15:0] cmd_word(logic [2:0] op, logic [15:0] extra);
        return dkr_pkg::CS_GO | {12'd0, op, 1'b0} | extra;
    endfunction

    task automatic add_beat(logic [1:0] func, logic [3:0] off, logic [15:0] data, logic bw);
        dkr_pkg::t_in_item b;
        b.func = func;
        b.reg_offset = off;
        b.write_data = data;
        b.byte_write = bw;
        pending_q.push_back(b);
    endtask

    task automatic queue_random(int count);
        dkr_pkg::t_in_item b;
        int                kind;
        logic [7:0]        cyl;
        logic [3:0]        sec;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(99);
            b.func = dkr_pkg::FUNC_WRITE;
            b.write_data = 16'($urandom);
            b.byte_write = ($urandom_range(99) < 15);
            b.reg_offset = {dkr_pkg::REG_CS, b.byte_write & 1'($urandom)};
            if (kind < 35) begin
                b.write_data[0] = ($urandom_range(99) < 85);
                b.write_data[10] = ($urandom_range(99) < 15);
                b.write_data[11] = ($urandom_range(99) < 30);
            end else if (kind < 55) begin
                cyl = ($urandom_range(99) < 85) ? 8'($urandom_range(202)) : 8'($urandom);
                sec = ($urandom_range(99) < 85) ? 4'($urandom_range(11)) : 4'($urandom);
                b.write_data = {3'($urandom), cyl, 1'($urandom), sec};
                b.reg_offset = {dkr_pkg::REG_DA, b.byte_write & 1'($urandom)};
            end else if (kind < 65) begin
                if ($urandom_range(99) < 60) b.write_data = 16'(0 - $urandom_range(1, 512));
                b.reg_offset = {dkr_pkg::REG_WC, b.byte_write & 1'($urandom)};
            end else if (kind < 72) begin
                b.reg_offset = {dkr_pkg::REG_BA, b.byte_write & 1'($urandom)};
            end else if (kind < 85) begin
                b.func = dkr_pkg::FUNC_READ;
                b.reg_offset = 4'($urandom);
            end else if (kind < 95) begin
                b.func = dkr_pkg::FUNC_ACK;
                b.reg_offset = 4'($urandom);
            end else begin
                b.func = 2'($urandom);
                b.reg_offset = 4'($urandom);
            end
            pending_q.push_back(b);
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_write_protect(logic v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WP_ADDR;
        pwdata <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        m_wlock = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // input beat acceptance and prediction
    always @(posedge i_clk) begin
        in_beat = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_beat = 1'b1;
            expected_q.push_back(predict_beat(i_in_item));
            void'(pending_q.pop_front());
            beats_in++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item <= pending_q[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        dkr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                flag_error($sformatf("unexpected result beat %h", o_out_item));
            end else begin
                want = expected_q.pop_front();
                cmp_field("read_data", o_out_item.read_data, want.read_data);
                cmp_field("irq", o_out_item.irq, want.irq);
                cmp_field("vector", o_out_item.vector, want.vector);
                cmp_field("xfer_start", o_out_item.xfer_start, want.xfer_start);
                cmp_field("xfer_kind", o_out_item.xfer_kind, want.xfer_kind);
                cmp_field("xfer_format", o_out_item.xfer_format, want.xfer_format);
                cmp_field("xfer_inhibit", o_out_item.xfer_inhibit, want.xfer_inhibit);
                cmp_field("xfer_disk_word", o_out_item.xfer_disk_word, want.xfer_disk_word);
                cmp_field("xfer_mem_addr", o_out_item.xfer_mem_addr, want.xfer_mem_addr);
                cmp_field("xfer_words", o_out_item.xfer_words, want.xfer_words);
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        rx_hold = 1'b0;
        while (beats_in < 250) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        beats_in = 0;
        err_count = 0;
        m_cs = dkr_pkg::CS_DONE;
        m_er = 16'd0;
        m_wc = 16'd0;
        m_ba = 16'd0;
        m_da = 16'd0;
        m_ivq = 2'b00;
        m_irq = 1'b0;
        m_wlock = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_write_protect(1'b0);
        add_beat(dkr_pkg::FUNC_READ, {dkr_pkg::REG_DS, 1'b0}, 16'd0, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_WC, 1'b0}, 16'h0000, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_BA, 1'b0}, 16'hFFFF, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_DA, 1'b0},
                 {3'b111, 8'd202, 1'b1, 4'd11}, 1'b0);
        // format read from the last sector: memory address wraps, disk address truncates
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_READ, dkr_pkg::CS_IE | dkr_pkg::CS_MEX | dkr_pkg::CS_FMT),
                 1'b0);
        add_beat(dkr_pkg::FUNC_READ, {dkr_pkg::REG_CS, 1'b0}, 16'd0, 1'b0);
        add_beat(dkr_pkg::FUNC_ACK, 4'd0, 16'd0, 1'b0);
        add_beat(dkr_pkg::FUNC_ACK, 4'd15, 16'hFFFF, 1'b1);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_DA, 1'b0}, 16'hFF00, 1'b1);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_DA, 1'b1}, 16'hFF00, 1'b1);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_WC, 1'b1}, 16'hFE00, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_WRITE, dkr_pkg::CS_INH), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_WCHK, 16'd0), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(OP_RD_CHECK, 16'd0), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_SEEK, dkr_pkg::CS_IE), 1'b0);
        add_beat(dkr_pkg::FUNC_ACK, 4'd0, 16'd0, 1'b0);
        add_beat(dkr_pkg::FUNC_ACK, 4'd0, 16'd0, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_DA, 1'b0}, 16'd15, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_READ, 16'd0), 1'b0);
        add_beat(dkr_pkg::FUNC_READ, {dkr_pkg::REG_ER, 1'b0}, 16'd0, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_DA, 1'b0},
                 {3'b000, 8'd255, 1'b0, 4'd0}, 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_SEEK, 16'd0), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_SEEK, dkr_pkg::CS_FMT), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_DRVRESET, dkr_pkg::CS_IE), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_WLOCK, 16'd0), 1'b0);
        add_beat(dkr_pkg::FUNC_WRITE, {dkr_pkg::REG_CS, 1'b0},
                 cmd_word(dkr_pkg::OP_CTLRESET, 16'd0), 1'b0);
        add_beat(FUNC_NONE, {dkr_pkg::REG_CS, 1'b0}, 16'hFFFF, 1'b1);
        add_beat(dkr_pkg::FUNC_WRITE, {REG_SPARE7, 1'b1}, 16'hFFFF, 1'b0);
        add_beat(dkr_pkg::FUNC_READ, {REG_SPARE6, 1'b1}, 16'd0, 1'b0);
        drain();

        set_write_protect(1'b1);
        tx_idle_pct = 11;
        rx_idle_pct = 82;
        queue_random(330);
        drain();

        set_write_protect(1'b0);
        tx_idle_pct = 82;
        rx_idle_pct = 11;
        queue_random(330);
        drain();

        set_write_protect(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(140);
        drain();

        set_write_protect(1'b0);
        queue_random(140);
        drain();

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
